// File: hw/rtl/tfc_pkg.sv
// ----------------------------------------------------------------------------
// tfc_pkg
// Shared types, constants and the CRC-16 byte update of the frame check
// field verifier and repairer.
// ----------------------------------------------------------------------------
package tfc_pkg;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h1021;

    localparam int MAX_RESULTS  = 3;
    localparam int OUTQ_DEPTH   = 4;
    localparam int OUTQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);
    localparam int PUSH_CNT_W   = $clog2(MAX_RESULTS + 1);

    localparam int APB_ADDR_W   = 3;
    localparam logic [0:0] REG_REPAIR_ENABLE = 1'b0;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_last;
        logic        fecf_ok;
        logic [15:0] computed_fecf;
        logic        too_short;
    } t_result;

    typedef struct packed {
        logic                  accept;
        logic [PUSH_CNT_W-1:0] count;
    } t_push_ctl;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        logic        fb;
        crc = crc_in;
        for (int i = 7; i >= 0; i--) begin
            fb  = crc[15] ^ data[i];
            crc = {crc[14:0], 1'b0};
            if (fb) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

// File: hw/rtl/tfc_if.sv
// ----------------------------------------------------------------------------
// tfc_in_if / tfc_out_if
// Valid/ready channels for incoming frame bytes and outgoing result items.
// ----------------------------------------------------------------------------
interface tfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tfc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        fecf_ok;
    logic [15:0] computed_fecf;
    logic        too_short;

    modport source (output valid, output out_byte, output out_last, output fecf_ok,
                    output computed_fecf, output too_short, input ready);
    modport sink   (input valid, input out_byte, input out_last, input fecf_ok,
                    input computed_fecf, input too_short, output ready);
endinterface

// File: hw/rtl/tfc_cfg.sv
// ----------------------------------------------------------------------------
// tfc_cfg
// APB register slave holding the repair enable bit.
// ----------------------------------------------------------------------------
module tfc_cfg
    import tfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic                  o_repair_enable
);

    logic r_repair_enable;
    logic n_repair_enable;
    logic wr_en;
    logic sel_repair;

    assign pready     = 1'b1;
    assign sel_repair = (paddr[APB_ADDR_W-1:2] == REG_REPAIR_ENABLE);
    assign wr_en      = psel && penable && pwrite && pready;

    always_comb begin
        n_repair_enable = r_repair_enable;
        if (wr_en && sel_repair) begin
            n_repair_enable = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repair_enable <= 1'b1;
        end else begin
            r_repair_enable <= n_repair_enable;
        end
    end

    assign prdata          = sel_repair ? {31'd0, r_repair_enable} : 32'd0;
    assign o_repair_enable = r_repair_enable;

endmodule

// File: hw/rtl/tfc_frame.sv
// ----------------------------------------------------------------------------
// tfc_frame
// Frame state: running CRC, two-byte delay line, check field compare and
// repair. Produces up to three result items per accepted byte.
// ----------------------------------------------------------------------------
module tfc_frame
    import tfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_repair_enable,
    output t_push_ctl  o_push_ctl,
    output t_result    o_push [MAX_RESULTS]
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_held [2];
    logic [7:0]  n_held [2];
    logic [1:0]  r_held_count;
    logic [1:0]  n_held_count;

    always_comb begin
        logic [15:0] crc_mid;
        logic [7:0]  h0;
        logic [7:0]  h1;
        logic [1:0]  cnt;
        logic [1:0]  k;
        logic        ok;
        logic [7:0]  hi;
        logic [7:0]  lo;

        crc_mid = r_crc;
        h0      = r_held[0];
        h1      = r_held[1];
        cnt     = r_held_count;
        k       = 2'd0;
        ok      = 1'b0;
        hi      = 8'd0;
        lo      = 8'd0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            o_push[i] = '0;
        end

        if (r_held_count[1]) begin
            crc_mid   = crc_byte(r_crc, r_held[0]);
            o_push[0] = '{out_byte: r_held[0], out_last: 1'b0, fecf_ok: 1'b0,
                          computed_fecf: 16'd0, too_short: 1'b0};
            k   = 2'd1;
            h0  = r_held[1];
            h1  = i_data_byte;
            cnt = 2'd2;
        end else if (r_held_count[0]) begin
            h1  = i_data_byte;
            cnt = 2'd2;
        end else begin
            h0  = i_data_byte;
            cnt = 2'd1;
        end

        if (i_last_byte) begin
            if (cnt[1]) begin
                ok = ({h0, h1} == crc_mid);
                hi = h0;
                lo = h1;
                if (!ok && i_repair_enable) begin
                    hi = crc_mid[15:8];
                    lo = crc_mid[7:0];
                end
                o_push[k] = '{out_byte: hi, out_last: 1'b0, fecf_ok: 1'b0,
                              computed_fecf: 16'd0, too_short: 1'b0};
                o_push[k + 2'd1] = '{out_byte: lo, out_last: 1'b1, fecf_ok: ok,
                                     computed_fecf: crc_mid, too_short: 1'b0};
                k = k + 2'd2;
            end else begin
                o_push[k] = '{out_byte: h0, out_last: 1'b1, fecf_ok: 1'b0,
                              computed_fecf: CRC_INIT, too_short: 1'b1};
                k = k + 2'd1;
            end
            n_crc        = CRC_INIT;
            n_held[0]    = 8'd0;
            n_held[1]    = 8'd0;
            n_held_count = 2'd0;
        end else begin
            n_crc        = crc_mid;
            n_held[0]    = h0;
            n_held[1]    = h1;
            n_held_count = cnt;
        end

        o_push_ctl.accept = i_accept;
        o_push_ctl.count  = i_accept ? PUSH_CNT_W'(k) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_held[0]    <= 8'd0;
            r_held[1]    <= 8'd0;
            r_held_count <= 2'd0;
        end else if (i_accept) begin
            r_crc        <= n_crc;
            r_held[0]    <= n_held[0];
            r_held[1]    <= n_held[1];
            r_held_count <= n_held_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last_byte |=> r_held_count == 2'd0 && r_crc == CRC_INIT)
        else $error("frame state not cleared after last byte");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count != 2'd3)
        else $error("held byte count out of range");

    a_push_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last_byte |-> o_push[o_push_ctl.count - 1'b1].out_last)
        else $error("final pushed item of a frame lacks out_last");
`endif

endmodule

// File: hw/rtl/tfc_outq.sv
// ----------------------------------------------------------------------------
// tfc_outq
// Result register queue: takes up to three items per cycle while it has
// room, issues one per cycle from its head register while the sink is ready.
// ----------------------------------------------------------------------------
module tfc_outq
    import tfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push_ctl i_push_ctl,
    input  t_result   i_push [MAX_RESULTS],
    output logic      o_can_accept,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_item
);

    t_result               r_entry [OUTQ_DEPTH];
    t_result               n_entry [OUTQ_DEPTH];
    logic [OUTQ_CNT_W-1:0] r_count;
    logic [OUTQ_CNT_W-1:0] n_count;
    logic                  pop;
    logic [OUTQ_CNT_W-1:0] base;

    assign pop  = (r_count != '0) && i_ready;
    assign base = r_count - OUTQ_CNT_W'(pop);

    always_comb begin
        logic [OUTQ_CNT_W-1:0] j;
        for (int i = 0; i < OUTQ_DEPTH; i++) begin
            j = OUTQ_CNT_W'(i) - base;
            if (OUTQ_CNT_W'(i) < base) begin
                n_entry[i] = pop ? r_entry[(i + 1) % OUTQ_DEPTH] : r_entry[i];
            end else if (j < OUTQ_CNT_W'(i_push_ctl.count)) begin
                n_entry[i] = i_push[j[PUSH_CNT_W-1:0]];
            end else begin
                n_entry[i] = r_entry[i];
            end
        end
        n_count = base + OUTQ_CNT_W'(i_push_ctl.count);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < OUTQ_DEPTH; i++) begin
            r_entry[i] <= n_entry[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_can_accept = (r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - MAX_RESULTS));
    assign o_valid      = (r_count != '0);
    assign o_item       = r_entry[0];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push_ctl.count != '0 |-> o_can_accept)
        else $error("items pushed without room");
`endif

endmodule

// File: hw/rtl/tc_frame_fecf_check_repair_core.sv
// ----------------------------------------------------------------------------
// tc_frame_fecf_check_repair_core
// Telecommand frame check field verifier and repairer (CRC-16, poly 0x1021).
// The items caused by a byte are in the output queue registers in the cycle
// after it is accepted; frame bytes leave two bytes behind their arrival.
// Input takes one byte per cycle while the output queue has room; a frame's
// last byte yields up to three items for the output queue, stalling input.
// Reset (synchronous, active low): frame state, queue cleared; repair on.
// ----------------------------------------------------------------------------
module tc_frame_fecf_check_repair_core
    import tfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tfc_in_if.sink                i_in,
    tfc_out_if.source             o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic      repair_enable;
    logic      can_accept;
    logic      accept;
    t_push_ctl push_ctl;
    t_result   push [MAX_RESULTS];
    t_result   head;

    tfc_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_repair_enable (repair_enable)
    );

    assign i_in.ready = can_accept;
    assign accept     = i_in.valid && can_accept;

    tfc_frame u_frame (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_in.data_byte),
        .i_last_byte     (i_in.last_byte),
        .i_repair_enable (repair_enable),
        .o_push_ctl      (push_ctl),
        .o_push          (push)
    );

    tfc_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_ctl   (push_ctl),
        .i_push       (push),
        .o_can_accept (can_accept),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_item       (head)
    );

    assign o_out.out_byte      = head.out_byte;
    assign o_out.out_last      = head.out_last;
    assign o_out.fecf_ok       = head.fecf_ok;
    assign o_out.computed_fecf = head.computed_fecf;
    assign o_out.too_short     = head.too_short;

endmodule

// File: tb/tb_tc_frame_fecf_check_repair_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tc_frame_fecf_check_repair_core
// Streams telecommand frames with good, corrupted and too-short check fields
// through the core under random source gaps and sink stalls. The repair
// setting is switched over the APB port between phases. A predictor keeps
// its own CRC, two-byte delay line and repair flag, and checks every output
// item against it in order.
// ----------------------------------------------------------------------------
module tb_tc_frame_fecf_check_repair_core
    import tfc_pkg::*;
();

    localparam int HALF_PERIOD    = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    class fecf_check_sb;
        bit          repair_en;
        logic [15:0] crc;
        logic [7:0]  held [2];
        int          held_cnt;
        t_result     pending_out_bytes [$];
        int          mismatches;

        function new();
            repair_en  = 1'b1;
            mismatches = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            crc      = CRC_INIT;
            held[0]  = 8'h00;
            held[1]  = 8'h00;
            held_cnt = 0;
        endfunction

        function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
            logic [15:0] v;
            v = c ^ {b, 8'h00};
            for (int k = 0; k < 8; k++) begin
                v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
            end
            return v;
        endfunction

        function void push(logic [7:0] b, logic last, logic ok, logic [15:0] f, logic shrt);
            t_result r;
            r.out_byte      = b;
            r.out_last      = last;
            r.fecf_ok       = ok;
            r.computed_fecf = f;
            r.too_short     = shrt;
            pending_out_bytes.push_back(r);
        endfunction

        function void take_byte(logic [7:0] b, logic last);
            logic [15:0] rx;
            logic [7:0]  hi;
            logic [7:0]  lo;
            logic        ok;
            if (held_cnt >= 2) begin
                crc = crc_step(crc, held[0]);
                push(held[0], 1'b0, 1'b0, 16'h0000, 1'b0);
                held[0] = held[1];
                held[1] = b;
            end else begin
                held[held_cnt] = b;
                held_cnt++;
            end
            if (last) begin
                if (held_cnt == 2) begin
                    rx = {held[0], held[1]};
                    ok = (rx == crc);
                    hi = held[0];
                    lo = held[1];
                    if (!ok && repair_en) begin
                        hi = crc[15:8];
                        lo = crc[7:0];
                    end
                    push(hi, 1'b0, 1'b0, 16'h0000, 1'b0);
                    push(lo, 1'b1, ok, crc, 1'b0);
                end else begin
                    push(held[0], 1'b1, 1'b0, CRC_INIT, 1'b1);
                end
                clear_frame();
            end
        endfunction

        function void report(string what, t_result want, t_result got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%s: exp byte=%02h last=%b ok=%b fecf=%04h short=%b,",
                         what, want.out_byte, want.out_last, want.fecf_ok,
                         want.computed_fecf, want.too_short,
                         " got byte=%02h last=%b ok=%b fecf=%04h short=%b",
                         got.out_byte, got.out_last, got.fecf_ok,
                         got.computed_fecf, got.too_short);
            end
        endfunction

        function void check_out_byte(t_result got);
            t_result want;
            if (pending_out_bytes.size() == 0) begin
                want = '0;
                report("unexpected item", want, got);
            end else begin
                want = pending_out_bytes.pop_front();
                if (got.out_byte !== want.out_byte || got.out_last !== want.out_last ||
                    got.fecf_ok !== want.fecf_ok ||
                    got.computed_fecf !== want.computed_fecf ||
                    got.too_short !== want.too_short) begin
                    report("item mismatch", want, got);
                end
            end
        endfunction

        function void close();
            mismatches += pending_out_bytes.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    tfc_in_if  in_if ();
    tfc_out_if out_if ();

    tc_frame_fecf_check_repair_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fecf_check_sb sb = new();
    logic [7:0]   frame_bytes [$];
    int           items_sent;
    bit           calm_in;
    int           idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
    end

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 50);
    endfunction

    // sink side: random ready pattern with calm stretches
    initial begin : sink_ready
        int run;
        int calm_left;
        int g;
        out_if.ready = 1'b0;
        run          = 0;
        calm_left    = 0;
        forever begin
            @(negedge i_clk);
            if (calm_left > 0) begin
                calm_left--;
            end else if ($urandom_range(0, 199) == 0) begin
                calm_left = $urandom_range(50, 150);
            end
            if (run == 0) begin
                g = pick_gap(calm_left > 0);
                if (g == 0) begin
                    out_if.ready <= 1'b1;
                    run = $urandom_range(1, 10);
                end else begin
                    out_if.ready <= 1'b0;
                    run = g;
                end
            end
            run--;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.out_byte      = out_if.out_byte;
            got.out_last      = out_if.out_last;
            got.fecf_ok       = out_if.fecf_ok;
            got.computed_fecf = out_if.computed_fecf;
            got.too_short     = out_if.too_short;
            sb.check_out_byte(got);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_tc_frame_fecf_check_repair_core: done, errors");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int g;
        g = pick_gap(calm_in);
        if (g > 0) begin
            in_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= last;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.take_byte(b, last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[k]) begin
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
    endtask

    function automatic void add_fecf(input bit good);
        logic [15:0] f;
        f = CRC_INIT;
        foreach (frame_bytes[k]) begin
            f = sb.crc_step(f, frame_bytes[k]);
        end
        if (!good) begin
            f = f ^ 16'($urandom_range(1, 16'hFFFF));
        end
        frame_bytes.push_back(f[15:8]);
        frame_bytes.push_back(f[7:0]);
    endfunction

    task automatic send_random_frame();
        int r;
        int body_len;
        r       = $urandom_range(0, 99);
        calm_in = ($urandom_range(0, 4) == 0);
        if (r < 5) begin
            body_len = -1;
        end else if (r < 10) begin
            body_len = 0;
        end else if (r < 90) begin
            body_len = $urandom_range(1, 12);
        end else begin
            body_len = $urandom_range(13, 40);
        end
        for (int k = 0; k < ((body_len < 0) ? 1 : body_len); k++) begin
            frame_bytes.push_back(8'($urandom));
        end
        if (body_len >= 0) begin
            add_fecf($urandom_range(0, 99) < 55);
        end
        send_frame();
    endtask

    task automatic run_until(input int target);
        while (items_sent < target) send_random_frame();
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (sb.pending_out_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_repair(input bit en);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_REPAIR_ENABLE, 2'b00};
        pwdata  <= {31'd0, en};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.repair_en = en;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_if.valid     = 1'b0;
        in_if.data_byte = 8'h00;
        in_if.last_byte = 1'b0;
        items_sent      = 0;
        calm_in         = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // repair on after reset: short frames, empty body, extremes
        frame_bytes = '{8'h00};
        send_frame();
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{8'hFF, 8'hFF};
        send_frame();
        frame_bytes = '{8'h00, 8'h00};
        send_frame();
        frame_bytes = '{8'h00, 8'hFF};
        add_fecf(1'b1);
        send_frame();
        frame_bytes = '{8'hFF, 8'h80, 8'h01};
        add_fecf(1'b0);
        send_frame();

        // repair off: bad field must pass through untouched
        set_repair(1'b0);
        frame_bytes = '{8'h7E, 8'hA5};
        add_fecf(1'b0);
        send_frame();
        frame_bytes = '{8'h5A};
        add_fecf(1'b1);
        send_frame();
        run_until(150);

        set_repair(1'b1);
        run_until(300);
        set_repair(1'b0);
        run_until(380);
        set_repair(1'b1);
        run_until(440);

        drain();
        sb.close();
        if (sb.mismatches == 0) begin
            $display("tb_tc_frame_fecf_check_repair_core: done, clean");
        end else begin
            $display("tb_tc_frame_fecf_check_repair_core: done, errors");
        end
        $finish;
    end

endmodule

// File: tc_frame_fecf_check_repair_core.f
hw/rtl/tfc_pkg.sv
hw/rtl/tfc_if.sv
hw/rtl/tfc_cfg.sv
hw/rtl/tfc_frame.sv
hw/rtl/tfc_outq.sv
hw/rtl/tc_frame_fecf_check_repair_core.sv
tb/tb_tc_frame_fecf_check_repair_core.sv
